// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition implies a property in the following cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/ghrt_pkg.sv
// Types and constants for the generational handle table.
`timescale 1ns / 1ps

package ghrt_pkg;

    typedef enum logic [2:0] {
        CMD_WATCH  = 3'd0,
        CMD_ARM    = 3'd1,
        CMD_CANCEL = 3'd2,
        CMD_READY  = 3'd3,
        CMD_FAIL   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WGEN,
        ST_SCAN,
        ST_SNOTE
    } state_t;

    // failure sweep notifies at most this many entries
    localparam int NOTE_CNT_W = 5;
    localparam logic [NOTE_CNT_W-1:0] FAIL_NOTE_MAX = 5'd16;

    typedef struct packed {
        logic        ok;
        logic [3:0]  slot;
        logic [31:0] gen;
        logic [63:0] sock;
        logic [31:0] cb;
        logic        notify;
        logic        last;
        logic [4:0]  reg_cnt;
        logic [4:0]  arm_cnt;
        logic [31:0] note_cnt;
        logic        running;
    } res_t;

endpackage

// File: rtl/core/ghrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ghrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/generation_handle_readiness_table_unit.sv
// Generational handle table: watch, arm, cancel, ready and failure commands.
// Arm, cancel, ready and refused commands give their beat after the entry RAM read;
//   watch does a free-stack read, then an entry RAM read-modify-write.
// Failure sweeps slots in order, one beat per notified entry (at most FAIL_NOTE_MAX).
// One item at a time: a new command is taken only in idle, after the last beat loads.
// Reset is asynchronous: marks, counters and RAM valid bits clear at once, no sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module generation_handle_readiness_table_unit
    import ghrt_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int GEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [2:0]  command,
    input  logic [63:0] socket_id,
    input  logic [31:0] callback_tag,
    input  logic [3:0]  slot,
    input  logic [31:0] token_generation,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        ok,
    output logic [3:0]  out_slot,
    output logic [31:0] out_generation,
    output logic [63:0] out_socket,
    output logic [31:0] out_callback,
    output logic        notify,
    output logic        last,
    output logic [4:0]  registered_count,
    output logic [4:0]  armed_count,
    output logic [31:0] notification_count,
    output logic        running
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 64 + 32 + GEN_BITS;

    state_t state_reg, state_next;

    logic [2:0]  cmd_reg;
    logic [63:0] sock_reg;
    logic [31:0] tag_reg;
    logic [3:0]  slot_reg;
    logic [31:0] tgen_reg;

    logic                  enabled_reg;
    logic                  failed_reg, failed_next;
    logic [CAPACITY-1:0]   active_reg, active_next;
    logic [CAPACITY-1:0]   armed_reg, armed_next;
    logic [CAPACITY-1:0]   written_reg, written_next;
    logic [CAPACITY-1:0]   fvalid_reg, fvalid_next;
    logic [CW-1:0]         free_count_reg, free_count_next;
    logic [CW-1:0]         active_total_reg, active_total_next;
    logic [CW-1:0]         armed_total_reg, armed_total_next;
    logic [31:0]           notify_total_reg, notify_total_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [NOTE_CNT_W-1:0] note_cnt_reg, note_cnt_next;
    logic [AW-1:0]         frd_idx_reg, frd_idx_next;
    res_t                  res_reg, res_fill;
    logic                  res_valid_reg;
    logic                  res_load;

    logic          ent_we, ent_re;
    logic [AW-1:0] ent_waddr, ent_raddr;
    logic [EW-1:0] ent_wdata, ent_rdata;
    logic          free_we, free_re;
    logic [AW-1:0] free_waddr, free_raddr;
    logic [AW-1:0] free_wdata, free_rdata;

    logic                accept;
    logic                is_running;
    logic                out_free;
    logic [AW-1:0]       e_idx;
    logic [GEN_BITS-1:0] e_gen, gen_inc, gen_new;
    logic [31:0]         e_cb;
    logic [63:0]         e_sock;
    logic                slot_in;
    logic                tok_ok;
    logic                watch_ok;
    logic [CW-1:0]       fc_dec;
    logic [AW-1:0]       free_top;
    logic                scan_done, scan_hit;

    ghrt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    ghrt_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .re    (free_re),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    assign accept     = cmd_valid && cmd_ready;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign is_running = enabled_reg && !failed_reg;
    assign out_free   = !res_valid_reg || res_ready;

    assign e_idx    = idx_reg[AW-1:0];
    assign e_gen    = written_reg[e_idx] ? ent_rdata[GEN_BITS-1:0] : '0;
    assign e_cb     = ent_rdata[GEN_BITS +: 32];
    assign e_sock   = ent_rdata[GEN_BITS + 32 +: 64];
    assign gen_inc  = e_gen + GEN_BITS'(1);
    assign gen_new  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
    assign slot_in  = 32'(slot_reg) < 32'(CAPACITY);
    assign tok_ok   = slot_in && active_reg[e_idx] && (64'(e_gen) == 64'(tgen_reg));
    assign watch_ok = is_running && (free_count_reg != '0) && (tag_reg != '0)
                      && (sock_reg != '1);
    assign fc_dec   = free_count_reg - CW'(1);
    // unwritten free-stack entries hold their reset order
    assign free_top = fvalid_reg[frd_idx_reg] ? free_rdata
                      : AW'(CAPACITY - 1 - int'(frd_idx_reg));

    assign scan_done = (idx_reg == CW'(CAPACITY)) || (note_cnt_reg == FAIL_NOTE_MAX);
    assign scan_hit  = !scan_done && active_reg[e_idx] && armed_reg[e_idx];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                unique case (cmd_reg)
                    CMD_WATCH:
                    begin
                        if (watch_ok)
                        begin
                            state_next = ST_WGEN;
                        end
                        else if (out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_FAIL:
                    begin
                        if (is_running)
                        begin
                            state_next = ST_SCAN;
                        end
                        else if (out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_WGEN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                priority if (scan_done)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (scan_hit)
                begin
                    state_next = ST_SNOTE;
                end
            end
            ST_SNOTE:
            begin
                if (out_free)
                begin
                    state_next = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        failed_next       = failed_reg;
        active_next       = active_reg;
        armed_next        = armed_reg;
        written_next      = written_reg;
        fvalid_next       = fvalid_reg;
        free_count_next   = free_count_reg;
        active_total_next = active_total_reg;
        armed_total_next  = armed_total_reg;
        notify_total_next = notify_total_reg;
        idx_next          = idx_reg;
        note_cnt_next     = note_cnt_reg;
        frd_idx_next      = frd_idx_reg;
        ent_we            = 1'b0;
        ent_waddr         = e_idx;
        ent_wdata         = {sock_reg, tag_reg, gen_new};
        ent_re            = 1'b0;
        ent_raddr         = e_idx;
        free_we           = 1'b0;
        free_waddr        = free_count_reg[AW-1:0];
        free_wdata        = e_idx;
        free_re           = 1'b0;
        free_raddr        = fc_dec[AW-1:0];
        res_load          = 1'b0;
        res_fill          = '0;
        res_fill.last     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ent_re       = 1'b1;
                    ent_raddr    = AW'(slot);
                    free_re      = (free_count_reg != '0);
                    frd_idx_next = fc_dec[AW-1:0];
                    idx_next     = CW'(slot);
                end
            end
            ST_READ:
            begin
                unique case (cmd_reg)
                    CMD_WATCH:
                    begin
                        if (watch_ok)
                        begin
                            ent_re    = 1'b1;
                            ent_raddr = free_top;
                            idx_next  = CW'(free_top);
                        end
                        else
                        begin
                            res_load = out_free;
                        end
                    end
                    CMD_ARM:
                    begin
                        res_load    = out_free;
                        res_fill.ok = is_running && tok_ok;
                        if (out_free && is_running && tok_ok && !armed_reg[e_idx])
                        begin
                            armed_next[e_idx] = 1'b1;
                            armed_total_next  = armed_total_reg + CW'(1);
                        end
                    end
                    CMD_CANCEL:
                    begin
                        res_load    = out_free;
                        res_fill.ok = tok_ok;
                        if (out_free && tok_ok)
                        begin
                            if (armed_reg[e_idx])
                            begin
                                armed_total_next = armed_total_reg - CW'(1);
                            end
                            active_total_next  = active_total_reg - CW'(1);
                            active_next[e_idx] = 1'b0;
                            armed_next[e_idx]  = 1'b0;
                            if (free_count_reg < CW'(CAPACITY))
                            begin
                                free_we                     = 1'b1;
                                fvalid_next[free_waddr]     = 1'b1;
                                free_count_next             = free_count_reg + CW'(1);
                            end
                        end
                    end
                    CMD_READY:
                    begin
                        res_load = out_free;
                        if (out_free && is_running && tok_ok && armed_reg[e_idx])
                        begin
                            armed_next[e_idx] = 1'b0;
                            armed_total_next  = armed_total_reg - CW'(1);
                            notify_total_next = notify_total_reg + 32'd1;
                            res_fill.ok       = 1'b1;
                            res_fill.slot     = 4'(e_idx);
                            res_fill.gen      = 32'(e_gen);
                            res_fill.sock     = e_sock;
                            res_fill.cb       = e_cb;
                            res_fill.notify   = 1'b1;
                        end
                    end
                    CMD_FAIL:
                    begin
                        if (is_running)
                        begin
                            failed_next   = 1'b1;
                            idx_next      = '0;
                            note_cnt_next = '0;
                        end
                        else
                        begin
                            res_load = out_free;
                        end
                    end
                    default:
                    begin
                        res_load = out_free;
                    end
                endcase
            end
            ST_WGEN:
            begin
                if (out_free)
                begin
                    ent_we              = 1'b1;
                    written_next[e_idx] = 1'b1;
                    active_next[e_idx]  = 1'b1;
                    armed_next[e_idx]   = 1'b0;
                    free_count_next     = fc_dec;
                    active_total_next   = active_total_reg + CW'(1);
                    res_load            = 1'b1;
                    res_fill.ok         = 1'b1;
                    res_fill.slot       = 4'(e_idx);
                    res_fill.gen        = 32'(gen_new);
                end
            end
            ST_SCAN:
            begin
                priority if (scan_done)
                begin
                    res_load    = out_free;
                    res_fill.ok = 1'b1;
                end
                else if (scan_hit)
                begin
                    ent_re = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_SNOTE:
            begin
                if (out_free)
                begin
                    armed_next[e_idx] = 1'b0;
                    armed_total_next  = armed_total_reg - CW'(1);
                    notify_total_next = notify_total_reg + 32'd1;
                    note_cnt_next     = note_cnt_reg + NOTE_CNT_W'(1);
                    idx_next          = idx_reg + CW'(1);
                    res_load          = 1'b1;
                    res_fill.ok       = 1'b1;
                    res_fill.slot     = 4'(e_idx);
                    res_fill.gen      = 32'(e_gen);
                    res_fill.sock     = e_sock;
                    res_fill.cb       = e_cb;
                    res_fill.notify   = 1'b1;
                    res_fill.last     = 1'b0;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase

        // counts reported after this beat's update
        res_fill.reg_cnt  = 5'(active_total_next);
        res_fill.arm_cnt  = 5'(armed_total_next);
        res_fill.note_cnt = notify_total_next;
        res_fill.running  = enabled_reg && !failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            enabled_reg      <= 1'b0;
            failed_reg       <= 1'b0;
            active_reg       <= '0;
            armed_reg        <= '0;
            written_reg      <= '0;
            fvalid_reg       <= '0;
            free_count_reg   <= CW'(CAPACITY);
            active_total_reg <= '0;
            armed_total_reg  <= '0;
            notify_total_reg <= '0;
            idx_reg          <= '0;
            note_cnt_reg     <= '0;
            frd_idx_reg      <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
            end
            failed_reg       <= failed_next;
            active_reg       <= active_next;
            armed_reg        <= armed_next;
            written_reg      <= written_next;
            fvalid_reg       <= fvalid_next;
            free_count_reg   <= free_count_next;
            active_total_reg <= active_total_next;
            armed_total_reg  <= armed_total_next;
            notify_total_reg <= notify_total_next;
            idx_reg          <= idx_next;
            note_cnt_reg     <= note_cnt_next;
            frd_idx_reg      <= frd_idx_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            sock_reg <= socket_id;
            tag_reg  <= callback_tag;
            slot_reg <= slot;
            tgen_reg <= token_generation;
        end
        if (res_load)
        begin
            res_reg <= res_fill;
        end
    end

    assign res_valid          = res_valid_reg;
    assign ok                 = res_reg.ok;
    assign out_slot           = res_reg.slot;
    assign out_generation     = res_reg.gen;
    assign out_socket         = res_reg.sock;
    assign out_callback       = res_reg.cb;
    assign notify             = res_reg.notify;
    assign last               = res_reg.last;
    assign registered_count   = res_reg.reg_cnt;
    assign armed_count        = res_reg.arm_cnt;
    assign notification_count = res_reg.note_cnt;
    assign running            = res_reg.running;

    `ASSERT_HOLDS(a_armed_le_active, armed_total_reg <= active_total_reg, "armed count above active count")
    `ASSERT_HOLDS(a_slot_balance, (32'(active_total_reg) + 32'(free_count_reg)) == 32'(CAPACITY), "active plus free slots mismatch")
    `ASSERT_HOLDS(a_active_pop, $countones(active_reg) == 32'(active_total_reg), "active count does not match marks")
    `ASSERT_HOLDS(a_armed_sub, (armed_reg & ~active_reg) == '0, "armed mark on inactive slot")
    `ASSERT_NEXT(a_accept_read, cmd_valid && cmd_ready, state_reg == ST_READ, "accepted beat did not start a lookup")

endmodule
